// ===== src/fpba_pkg.sv =====
// Shared types and constants for the fit-policy block allocator.
// No dependencies; imported by every module of the block.
package fpba_pkg;

    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_WIDTH_DEF = 16;

    localparam int FIELD_SIZE_W  = 16;
    localparam int FIELD_INDEX_W = 4;
    localparam int CFG_DATA_W    = 5;
    localparam int CFG_INDEX_W   = 1;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_NEXT  = 2'd2;
    localparam logic [1:0] MODE_WORST = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIT_MODE      = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCKS_IN_USE = 1'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic scan;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== src/fpba_dp.sv =====
// Datapath: free-space table memory with valid bits, scan and select unit,
// configuration registers and result register. Depends on fpba_pkg.
module fpba_dp import fpba_pkg::*; #(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    input  logic [FIELD_INDEX_W-1:0] i_block_index,
    input  logic [FIELD_SIZE_W-1:0]  i_amount,
    input  logic                     i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic                     o_found,
    output logic [FIELD_INDEX_W-1:0] o_chosen_block,
    output logic [FIELD_SIZE_W-1:0]  o_space_left
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    logic [SIZE_WIDTH-1:0]    r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0]    r_vld;
    logic [1:0]               r_fit_mode;
    logic [CFG_DATA_W-1:0]    r_blocks;
    logic [IDX_W-1:0]         r_ptr;
    logic [SIZE_WIDTH-1:0]    r_amt;
    logic [IDX_W-1:0]         r_addr;
    logic [CNT_W-1:0]         r_left;
    logic [CNT_W-1:0]         r_count;
    logic                     r_rd_pend;
    logic [IDX_W-1:0]         r_rd_idx;
    logic [SIZE_WIDTH-1:0]    r_rd_data;
    logic                     r_rd_vld;
    logic                     r_hit;
    logic [IDX_W-1:0]         r_pick;
    logic [SIZE_WIDTH-1:0]    r_best;
    logic                     r_out_valid;
    logic                     r_out_found;
    logic [FIELD_INDEX_W-1:0] r_out_block;
    logic [FIELD_SIZE_W-1:0]  r_out_space;

    logic [CNT_W-1:0]      cnt_sat;
    logic [IDX_W-1:0]      start_pos;
    logic                  issue;
    logic [IDX_W-1:0]      addr_nxt;
    logic [SIZE_WIDTH-1:0] rd_val;
    logic                  take;
    logic [SIZE_WIDTH-1:0] remain;
    logic                  load_ok;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [SIZE_WIDTH-1:0] wr_data;

    always_comb begin
        cnt_sat   = (32'(r_blocks) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(r_blocks);
        start_pos = (r_fit_mode == MODE_NEXT && CNT_W'(r_ptr) < cnt_sat) ? r_ptr : '0;
        issue     = i_cmd.scan && (r_left != '0);
        addr_nxt  = (CNT_W'(r_addr) + CNT_W'(1) == r_count) ? '0 : r_addr + IDX_W'(1);
        rd_val    = r_rd_vld ? r_rd_data : '0;
        take      = (rd_val >= r_amt)
                    && (!r_hit
                        || (r_fit_mode == MODE_BEST && rd_val < r_best)
                        || (r_fit_mode == MODE_WORST && rd_val > r_best));
        remain    = r_best - r_amt;
        load_ok   = 32'(i_block_index) < NUM_BLOCKS;
        wr_en     = (i_cmd.load && load_ok) || (i_cmd.commit && r_hit);
        wr_addr   = i_cmd.load ? IDX_W'(i_block_index) : r_pick;
        wr_data   = i_cmd.load ? SIZE_WIDTH'(i_amount) : remain;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_addr];
            r_rd_idx  <= r_addr;
        end
        if (i_cmd.start) begin
            r_amt   <= SIZE_WIDTH'(i_amount);
            r_count <= cnt_sat;
        end
        if (r_rd_pend && take) begin
            r_pick <= r_rd_idx;
            r_best <= rd_val;
        end
        if (i_cmd.commit) begin
            r_out_found <= r_hit;
            r_out_block <= r_hit ? FIELD_INDEX_W'(r_pick) : '0;
            r_out_space <= r_hit ? FIELD_SIZE_W'(remain) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_fit_mode  <= MODE_FIRST;
            r_blocks    <= CFG_DATA_W'(16);
            r_ptr       <= '0;
            r_addr      <= '0;
            r_left      <= '0;
            r_rd_pend   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FIT_MODE:      r_fit_mode <= i_cfg_data[1:0];
                    CFG_BLOCKS_IN_USE: r_blocks   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_ptr <= '0;
            end else if (i_cmd.commit && r_hit && r_fit_mode == MODE_NEXT) begin
                r_ptr <= r_pick;
            end
            if (i_cmd.start) begin
                r_addr <= start_pos;
                r_left <= cnt_sat;
                r_hit  <= 1'b0;
            end else if (issue) begin
                r_addr <= addr_nxt;
                r_left <= r_left - CNT_W'(1);
            end
            if (issue) begin
                r_rd_vld <= r_vld[r_addr];
            end
            r_rd_pend <= issue;
            if (r_rd_pend && take) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.scan_done = (r_left == '0) && !r_rd_pend;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_found         = r_out_found;
    assign o_chosen_block  = r_out_block;
    assign o_space_left    = r_out_space;

endmodule

// ===== src/fpba_ctrl.sv =====
// Controller: sequences load, scan and commit of each item.
// Depends on fpba_pkg; drives the datapath through t_dp_cmd.
module fpba_ctrl import fpba_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_op,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_op == OP_REQUEST) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.load  = i_in_valid && i_op == OP_LOAD;
                o_cmd.start = i_in_valid && i_op == OP_REQUEST;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ===== src/fit_policy_block_allocator.sv =====
// A load beat writes one free-space entry and returns the next-fit pointer to
// zero. After a request beat the input stalls while blocks_in_use entries
// (saturated at NUM_BLOCKS) are searched and the pick is committed, so a new
// request is taken only after the previous one commits: the table sits in a
// one-port memory with registered read data, read once per searched entry, then
// the last compare finishes, the scan is seen done, and the pick is committed
// and the result register loaded. The commit waits while the previous result
// is still stalled at the output. A new beat is taken while a result still
// waits at the output. After reset every entry reads as zero.
module fit_policy_block_allocator import fpba_pkg::*; #(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_op,
    input  logic [FIELD_INDEX_W-1:0] i_block_index,
    input  logic [FIELD_SIZE_W-1:0]  i_amount,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_found,
    output logic [FIELD_INDEX_W-1:0] o_chosen_block,
    output logic [FIELD_SIZE_W-1:0]  o_space_left,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    fpba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    fpba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_block_index  (i_block_index),
        .i_amount       (i_amount),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_found        (o_found),
        .o_chosen_block (o_chosen_block),
        .o_space_left   (o_space_left)
    );

endmodule

// ===== src/fpba_checker.sv =====
// Port-level checker for the allocator, attached by bind.
// Depends on fpba_pkg and the fit_policy_block_allocator ports.
module fpba_checker import fpba_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic                     i_op,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic                     o_found,
    input logic [FIELD_INDEX_W-1:0] o_chosen_block,
    input logic [FIELD_SIZE_W-1:0]  o_space_left
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_chosen_block == '0 && o_space_left == '0)
        else $error("failed request carries nonzero fields");

    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_op == OP_REQUEST |=> o_in_stall)
        else $error("request beat not held for its scan");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_op == OP_LOAD |=> !o_in_stall)
        else $error("load beat stalled the input");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_op           (i_op),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_found        (o_found),
    .o_chosen_block (o_chosen_block),
    .o_space_left   (o_space_left)
);
